[design/unr_pkg.sv]
// Shared types and constants for the unsigned non-restoring divider.
package unr_pkg;

  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned WIDTH_DEF = 32;

  // Control that travels alongside the data in every pipeline stage
  typedef struct packed {
    logic valid;
    logic dz;
  } unr_ctl_t;

endpackage

[design/unr_step.sv]
// One non-restoring division step with its pipeline register.
module unr_step #(
  parameter int unsigned WIDTH = unr_pkg::WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  unr_pkg::unr_ctl_t up_ctl,
  input  logic [WIDTH:0]    up_rem,
  input  logic [WIDTH-1:0]  up_quo,
  input  logic [WIDTH-1:0]  up_dvs,
  output logic              up_ready,
  output unr_pkg::unr_ctl_t dn_ctl,
  output logic [WIDTH:0]    dn_rem,
  output logic [WIDTH-1:0]  dn_quo,
  output logic [WIDTH-1:0]  dn_dvs,
  input  logic              dn_ready
);
  import unr_pkg::*;

  unr_ctl_t         ctl_r;
  logic [WIDTH:0]   rem_r, rem_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] dvs_r;
  logic [WIDTH:0]   shifted;

  // Shift the remainder/quotient pair, then add or subtract by the old sign
  always_comb begin
    shifted = {up_rem[WIDTH-1:0], up_quo[WIDTH-1]};
    if (up_rem[WIDTH]) begin
      rem_nxt = shifted + {1'b0, up_dvs};
    end else begin
      rem_nxt = shifted - {1'b0, up_dvs};
    end
    quo_nxt = {up_quo[WIDTH-2:0], ~rem_nxt[WIDTH]};
  end

  assign up_ready = !ctl_r.valid || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (up_ready) begin
      ctl_r <= up_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_ctl.valid) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      dvs_r <= up_dvs;
    end
  end

  assign dn_ctl = ctl_r;
  assign dn_rem = rem_r;
  assign dn_quo = quo_r;
  assign dn_dvs = dvs_r;

endmodule

[design/unr_fix.sv]
// Final remainder correction and output register.
module unr_fix #(
  parameter int unsigned WIDTH = unr_pkg::WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  unr_pkg::unr_ctl_t up_ctl,
  input  logic [WIDTH:0]    up_rem,
  input  logic [WIDTH-1:0]  up_quo,
  input  logic [WIDTH-1:0]  up_dvs,
  output logic              up_ready,
  output logic              res_valid,
  output logic [WIDTH-1:0]  res_quo,
  output logic [WIDTH-1:0]  res_rem,
  output logic              res_dz,
  input  logic              res_ready
);
  import unr_pkg::*;

  unr_ctl_t         ctl_r;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] dvs_r;
  logic [WIDTH:0]   sum;

  always_comb begin
    sum = up_rem[WIDTH] ? up_rem + {1'b0, up_dvs} : up_rem;
    // Force zeros on a zero divisor
    rem_nxt = up_ctl.dz ? '0 : sum[WIDTH-1:0];
    quo_nxt = up_ctl.dz ? '0 : up_quo;
  end

  assign up_ready = !ctl_r.valid || res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (up_ready) begin
      ctl_r <= up_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_ctl.valid) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      dvs_r <= up_dvs;
    end
  end

  assign res_valid = ctl_r.valid;
  assign res_quo   = quo_r;
  assign res_rem   = rem_r;
  assign res_dz    = ctl_r.dz;

  a_rem_below_dvs: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.valid && !ctl_r.dz |-> rem_r < dvs_r)
    else $error("corrected remainder not below divisor");

endmodule

[design/unsigned_nonrestoring_divider.sv]
// Top level of the pipelined unsigned non-restoring divider.
//
//  channel | ports     | direction | content
//  --------+-----------+-----------+-----------------------------------------
//  in      | in_t*     | slave     | tdata: dividend, divisor
//  out     | out_t*    | master    | tdata: quotient, remainder; tuser: div0
//
// There is one register per division step, then one for the final correction
// and output. One item enters per cycle when nothing stalls.
// Each stage holds its item while the next stage is full and stalled; bubbles
// are filled, so the input keeps flowing while a result waits at the output.
// rst_n (synchronous) clears only the stage control bits (valid and dz).
module unsigned_nonrestoring_divider #(
  parameter int unsigned WIDTH = unr_pkg::WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [2*unr_pkg::FIELD_W-1:0] in_tdata,  // dividend[31:0], divisor[63:32]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [2*unr_pkg::FIELD_W-1:0] out_tdata, // quotient[31:0], remainder[63:32]
  output logic                       out_tuser     // divide_by_zero
);
  import unr_pkg::*;

  unr_ctl_t         stg_ctl   [WIDTH+1];
  logic [WIDTH:0]   stg_rem   [WIDTH+1];
  logic [WIDTH-1:0] stg_quo   [WIDTH+1];
  logic [WIDTH-1:0] stg_dvs   [WIDTH+1];
  logic             stg_ready [WIDTH+1];

  logic [WIDTH-1:0] res_quo, res_rem;

  always_comb begin
    stg_dvs[0]       = WIDTH'(in_tdata[2*FIELD_W-1:FIELD_W]);
    stg_quo[0]       = WIDTH'(in_tdata[FIELD_W-1:0]);
    stg_rem[0]       = '0;
    stg_ctl[0].valid = in_tvalid;
    stg_ctl[0].dz    = (stg_dvs[0] == '0);
  end

  assign in_tready = stg_ready[0];

  for (genvar i = 0; i < WIDTH; i++) begin : g_step
    unr_step #(.WIDTH(WIDTH)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_ctl   (stg_ctl[i]),
      .up_rem   (stg_rem[i]),
      .up_quo   (stg_quo[i]),
      .up_dvs   (stg_dvs[i]),
      .up_ready (stg_ready[i]),
      .dn_ctl   (stg_ctl[i+1]),
      .dn_rem   (stg_rem[i+1]),
      .dn_quo   (stg_quo[i+1]),
      .dn_dvs   (stg_dvs[i+1]),
      .dn_ready (stg_ready[i+1])
    );
  end

  unr_fix #(.WIDTH(WIDTH)) u_fix (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_ctl    (stg_ctl[WIDTH]),
    .up_rem    (stg_rem[WIDTH]),
    .up_quo    (stg_quo[WIDTH]),
    .up_dvs    (stg_dvs[WIDTH]),
    .up_ready  (stg_ready[WIDTH]),
    .res_valid (out_tvalid),
    .res_quo   (res_quo),
    .res_rem   (res_rem),
    .res_dz    (out_tuser),
    .res_ready (out_tready)
  );

  assign out_tdata = {FIELD_W'(res_rem), FIELD_W'(res_quo)};

  a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> stg_ctl[1].valid)
    else $error("accepted item missing from first stage");

  a_dz_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("nonzero result on zero divisor");

  a_stall_backs_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && stg_ctl[WIDTH].valid |-> !stg_ready[WIDTH])
    else $error("last step stage advanced into a stalled output");

endmodule

[tb/unsigned_nonrestoring_divider_tb.sv]
// Self-checking testbench for the pipelined unsigned non-restoring divider.
module unsigned_nonrestoring_divider_tb;
  import unr_pkg::*;

  localparam int RANDOM_ITEMS = 528;
  localparam int DRAIN_CYCLES = WIDTH_DEF + 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int NUM_ROWS     = 22;

  typedef logic [FIELD_W-1:0] word_t;

  typedef struct packed {
    word_t quotient;
    word_t remainder;
    logic  divide_by_zero;
  } quot_rem_t;

  typedef struct {
    word_t     dividend;
    word_t     divisor;
    bit        typed;
    quot_rem_t res;
  } div_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [2*FIELD_W-1:0]   in_tdata;   // dividend, divisor
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [2*FIELD_W-1:0]   out_tdata;  // quotient, remainder
  logic                   out_tuser;  // divide_by_zero

  quot_rem_t pending_results[$];
  quot_rem_t want;
  int        mismatch_count = 0;
  int        results_checked = 0;
  int        div_sent = 0;
  int        div_by_zero_sent = 0;
  int        idle_cycles = 0;
  int        rx_left = 0;
  int        burst_left = 0;

  // Typed rows are read straight off the arithmetic; the others go to the predictor
  div_row_t div_table [NUM_ROWS] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b1}},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b1}},
    '{32'h1234_5678, 32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b1}},
    '{32'h0000_0000, 32'h0000_0001, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b0}},
    '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0001, 32'h0000_0000, 1'b0}},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b0}},
    '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 32'h0000_0001, 1'b0}},
    '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 32'hFFFF_FFFE, 1'b0}},
    '{32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h0000_0001, 32'h0000_0000, 1'b0}},
    '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{32'h0000_0000, 32'h7FFF_FFFF, 1'b0}},
    '{32'hFFFF_FFFF, 32'h8000_0000, 1'b1, '{32'h0000_0001, 32'h7FFF_FFFF, 1'b0}},
    '{32'hFFFF_FFFF, 32'h0000_0002, 1'b1, '{32'h7FFF_FFFF, 32'h0000_0001, 1'b0}},
    '{32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h8000_0000, 32'h0000_0000, 1'b0}},
    '{32'h0000_0001, 32'h0000_0001, 1'b1, '{32'h0000_0001, 32'h0000_0000, 1'b0}},
    '{32'h0000_0001, 32'h0000_0002, 1'b1, '{32'h0000_0000, 32'h0000_0001, 1'b0}},
    '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, '{32'h0000_0002, 32'h0000_0001, 1'b0}},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b1, '{32'h0000_0002, 32'h0000_0000, 1'b0}},
    '{32'h0000_0064, 32'h0000_0007, 1'b0, '{32'h0, 32'h0, 1'b0}},
    '{32'hDEAD_BEEF, 32'h0000_1234, 1'b0, '{32'h0, 32'h0, 1'b0}},
    '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '{32'h0, 32'h0, 1'b0}},
    '{32'hFEDC_BA98, 32'h0000_0003, 1'b0, '{32'h0, 32'h0, 1'b0}}
  };

  unsigned_nonrestoring_divider dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shift-and-add/subtract division on a sign-extended partial remainder
  function automatic quot_rem_t divide_nonrestoring(word_t dividend, word_t divisor);
    quot_rem_t       r;
    logic [FIELD_W:0] part_rem;
    word_t           quot;
    logic            was_neg;
    r = '0;
    if (divisor == '0) begin
      r.divide_by_zero = 1'b1;
      return r;
    end
    part_rem = '0;
    quot     = dividend;
    for (int i = 0; i < FIELD_W; i++) begin
      was_neg  = part_rem[FIELD_W];
      part_rem = {part_rem[FIELD_W-1:0], quot[FIELD_W-1]};
      quot     = quot << 1;
      if (was_neg) part_rem = part_rem + {1'b0, divisor};
      else         part_rem = part_rem - {1'b0, divisor};
      quot[0] = ~part_rem[FIELD_W];
    end
    if (part_rem[FIELD_W]) part_rem = part_rem + {1'b0, divisor};
    r.quotient  = quot;
    r.remainder = part_rem[FIELD_W-1:0];
    return r;
  endfunction

  // Present one item at a falling edge and hold it until it is taken
  task automatic send_division(word_t dividend, word_t divisor, quot_rem_t result);
    in_tvalid <= 1'b1;
    in_tdata  <= {divisor, dividend};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(result);
    div_sent++;
    if (divisor == '0) div_by_zero_sent++;
    @(negedge clk);
    if (burst_left == 0) begin
      pause_sender($urandom_range(1, 8));
      burst_left = $urandom_range(0, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic pause_sender(int cycles);
    in_tvalid <= 1'b0;
    in_tdata  <= {$urandom, $urandom};
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain_sender();
    pause_sender(1);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Receiver: ready runs broken by stalls of a length picked per run
  always @(negedge clk) begin
    if (rx_left > 0) begin
      rx_left <= rx_left - 1;
    end else if (out_tready) begin
      case ($urandom_range(0, 2))
        0: rx_left <= $urandom_range(0, 31);
        1: begin
          out_tready <= 1'b0;
          rx_left    <= $urandom_range(0, 2);
        end
        default: begin
          out_tready <= 1'b0;
          rx_left    <= $urandom_range(3, 19);
        end
      endcase
    end else begin
      out_tready <= 1'b1;
      rx_left    <= $urandom_range(0, 15);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: quotient %h remainder %h divide_by_zero %b",
               out_tdata[FIELD_W-1:0], out_tdata[2*FIELD_W-1:FIELD_W], out_tuser);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_tdata[FIELD_W-1:0] !== want.quotient) begin
          $error("quotient: expected %h, got %h", want.quotient, out_tdata[FIELD_W-1:0]);
          mismatch_count++;
        end
        if (out_tdata[2*FIELD_W-1:FIELD_W] !== want.remainder) begin
          $error("remainder: expected %h, got %h", want.remainder,
                 out_tdata[2*FIELD_W-1:FIELD_W]);
          mismatch_count++;
        end
        if (out_tuser !== want.divide_by_zero) begin
          $error("divide_by_zero: expected %b, got %b", want.divide_by_zero, out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    word_t dividend;
    word_t divisor;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    pause_sender(2);

    foreach (div_table[i]) begin
      send_division(div_table[i].dividend, div_table[i].divisor,
                    div_table[i].typed ? div_table[i].res
                                       : divide_nonrestoring(div_table[i].dividend,
                                                             div_table[i].divisor));
    end
    drain_sender();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 99)) inside
        [0:4]: begin
          dividend = $urandom;
          divisor  = '0;
        end
        [5:29]: begin
          dividend = $urandom;
          divisor  = $urandom_range(1, 255);
        end
        [30:44]: begin
          divisor  = $urandom >> $urandom_range(0, 28);
          dividend = divisor * $urandom_range(0, 7) + $urandom_range(0, 3);
        end
        [45:54]: begin
          divisor  = $urandom | 32'h1;
          dividend = $urandom % divisor;
        end
        [55:64]: begin
          dividend = $urandom;
          divisor  = word_t'(1) << $urandom_range(0, FIELD_W - 1);
        end
        default: begin
          dividend = $urandom >> $urandom_range(0, 4);
          divisor  = $urandom >> $urandom_range(0, FIELD_W - 1);
        end
      endcase
      send_division(dividend, divisor, divide_nonrestoring(dividend, divisor));
      // Let the pipeline run dry once in the middle of the random part
      if (n == RANDOM_ITEMS / 2) drain_sender();
    end

    pause_sender(1);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatch_count++;
    end
    $display("Ran %0d divisions (%0d with a zero divisor), %0d results compared;",
             div_sent, div_by_zero_sent, results_checked);
    $display("directed edge cases, bursty random operands and random output stalls.");
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/unr_pkg.sv
design/unr_step.sv
design/unr_fix.sv
design/unsigned_nonrestoring_divider.sv
tb/unsigned_nonrestoring_divider_tb.sv
